/* rtl/stbs_pkg.sv */
// shared types and constants of the sorted table search block
package stbs_pkg;

  localparam int unsigned KEY_W       = 32;
  localparam int unsigned COST_W      = 32;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned CNT_W       = 9;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned REC_W       = KEY_W + COST_W;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 56;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_SORT   = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } stat_e;

  // controller to datapath commands
  typedef struct packed {
    logic  cap;         // take key and cost of the accepted word
    logic  app_wr;      // write record at the end of the table
    logic  set_sorted;  // table is now in key order
    logic  srt_init;    // outer sort index to one
    logic  rd_i;        // read entry at outer index
    logic  cap_k;       // hold entry being inserted
    logic  rd_jm1;      // read entry left of insert position
    logic  shift_wr;    // move left entry one place right
    logic  place_wr;    // drop held entry at insert position
    logic  srch_init;   // search bounds to full table
    logic  probe;       // read entry at midpoint
    logic  hit_cap;     // hold index and cost of the match
    logic  srch_upd;    // narrow search bounds
    logic  res_wr;      // load output register
    stat_e res_code;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic full;
    logic sorted;
    logic i_done;
    logic j_zero;
    logic key_gt;   // left entry key above held key
    logic open;     // search range not empty
    logic hit;      // probed key equals searched key
    logic out_busy;
  } sts_t;

endpackage

/* rtl/stbs_dp.sv */
// datapath: record memory, sort and search counters, output register
module stbs_dp #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  stbs_pkg::ctl_t                  ctl_i,
  output stbs_pkg::sts_t                  sts_o,
  input  logic [stbs_pkg::IN_TDATA_W-1:0] in_tdata_i,   // key, cost
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [stbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o, // found_index, found_cost,
                                                          // entry_count, zero fill
  output logic [stbs_pkg::STAT_W-1:0]     m_axis_tuser_o  // status
);
  import stbs_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // table memory, one word per record: cost above key
  logic [REC_W-1:0] mem_q [TABLE_DEPTH];
  logic [REC_W-1:0] rd_q;
  logic [AW-1:0]    rd_addr;
  logic             we;
  logic [AW-1:0]    wa;
  logic [REC_W-1:0] wd;

  logic signed [KEY_W-1:0] key_q, k_q;
  logic [COST_W-1:0]       cost_q, c_q;
  logic [CW-1:0]           count_q, i_q, low_q, high_q;
  logic [AW-1:0]           j_q, mid_q, mid;
  logic [CW:0]             sum;
  logic                    sorted_q;
  logic [AW-1:0]           res_idx_q;
  logic [COST_W-1:0]       res_cost_q;
  logic                    out_valid_q;
  logic [STAT_W-1:0]       out_stat_q;
  logic [OUT_TDATA_W-1:0]  out_data_q;
  logic signed [KEY_W-1:0] rd_key;

  assign rd_key = rd_q[KEY_W-1:0];
  assign sum    = {1'b0, low_q} + {1'b0, high_q};
  assign mid    = sum[AW:1];

  // memory address and write data selection
  always_comb begin
    if (ctl_i.rd_i) begin
      rd_addr = i_q[AW-1:0];
    end else if (ctl_i.rd_jm1) begin
      rd_addr = j_q - AW'(1);
    end else begin
      rd_addr = mid;
    end
    we = ctl_i.app_wr | ctl_i.shift_wr | ctl_i.place_wr;
    wa = ctl_i.app_wr ? count_q[AW-1:0] : j_q;
    if (ctl_i.shift_wr) begin
      wd = rd_q;
    end else if (ctl_i.app_wr) begin
      wd = {cost_q, key_q};
    end else begin
      wd = {c_q, k_q};
    end
  end

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      key_q      <= in_tdata_i[KEY_W-1:0];
      cost_q     <= in_tdata_i[KEY_W +: COST_W];
      res_idx_q  <= '0;
      res_cost_q <= '0;
    end
    if (ctl_i.srt_init) begin
      i_q <= CW'(1);
    end else if (ctl_i.place_wr) begin
      i_q <= i_q + CW'(1);
    end
    if (ctl_i.cap_k) begin
      k_q <= rd_key;
      c_q <= rd_q[KEY_W +: COST_W];
      j_q <= i_q[AW-1:0];
    end else if (ctl_i.shift_wr) begin
      j_q <= j_q - AW'(1);
    end
    if (ctl_i.srch_init) begin
      low_q  <= '0;
      high_q <= count_q;
    end else if (ctl_i.srch_upd) begin
      if (key_q < rd_key) begin
        high_q <= CW'(mid_q);
      end else begin
        low_q <= CW'(mid_q) + CW'(1);
      end
    end
    if (ctl_i.probe) begin
      mid_q <= mid;
    end
    if (ctl_i.hit_cap) begin
      res_idx_q  <= mid_q;
      res_cost_q <= rd_q[KEY_W +: COST_W];
    end
    if (ctl_i.res_wr) begin
      out_stat_q <= ctl_i.res_code;
      out_data_q <= {7'd0, CNT_W'(count_q), res_cost_q, IDX_W'(res_idx_q)};
    end
  end

  // record count, sorted flag and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sorted_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.app_wr) begin
        count_q  <= count_q + CW'(1);
        sorted_q <= 1'b0;
      end else if (ctl_i.set_sorted) begin
        sorted_q <= 1'b1;
      end
      if (ctl_i.res_wr) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // status back to controller
  always_comb begin
    sts_o.full     = (count_q >= CW'(TABLE_DEPTH));
    sts_o.sorted   = sorted_q;
    sts_o.i_done   = (i_q >= count_q);
    sts_o.j_zero   = (j_q == '0);
    sts_o.key_gt   = (rd_key > k_q);
    sts_o.open     = (low_q < high_q);
    sts_o.hit      = (rd_key == key_q);
    sts_o.out_busy = out_valid_q & ~m_axis_tready_i;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_stat_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH)) else $error("record count beyond table depth");
  a_app_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.app_wr |-> !sts_o.full) else $error("append into full table");
  a_app_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.app_wr |=> count_q == $past(count_q) + CW'(1)) else $error("count not advanced");
  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.res_wr |-> !sts_o.out_busy) else $error("result overwrites pending word");
  a_probe_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.probe |-> low_q < high_q) else $error("probe on empty range");

endmodule

/* rtl/stbs_ctrl.sv */
// controller: command sequencing for append, insertion sort and binary search
module stbs_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [stbs_pkg::CMD_W-1:0]  cmd_i,
  input  stbs_pkg::sts_t              sts_i,
  output stbs_pkg::ctl_t              ctl_o
);
  import stbs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPEND,
    S_SRT_LD,
    S_SRT_LDW,
    S_SRT_RD,
    S_SRT_CMP,
    S_PROBE,
    S_SCMP,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  stat_e  code_q, code_d;
  logic   srch_q, srch_d;
  logic   accept;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  // next state and datapath commands
  always_comb begin
    state_d        = state_q;
    code_d         = code_q;
    srch_d         = srch_q;
    ctl_o          = '0;
    ctl_o.res_code = code_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ctl_o.cap = 1'b1;
          code_d    = ST_OK;
          srch_d    = 1'b0;
          case (cmd_i)
            CMD_APPEND: state_d = S_APPEND;
            CMD_SORT, CMD_SEARCH: begin
              srch_d = (cmd_i == CMD_SEARCH);
              if (sts_i.sorted) begin
                if (cmd_i == CMD_SEARCH) begin
                  ctl_o.srch_init = 1'b1;
                  state_d         = S_PROBE;
                end else begin
                  state_d = S_DONE;
                end
              end else begin
                ctl_o.srt_init = 1'b1;
                state_d        = S_SRT_LD;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_APPEND: begin
        if (sts_i.full) begin
          code_d = ST_FULL;
        end else begin
          ctl_o.app_wr = 1'b1;
        end
        state_d = S_DONE;
      end
      // insertion sort, outer step
      S_SRT_LD: begin
        if (sts_i.i_done) begin
          ctl_o.set_sorted = 1'b1;
          if (srch_q) begin
            ctl_o.srch_init = 1'b1;
            state_d         = S_PROBE;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          ctl_o.rd_i = 1'b1;
          state_d    = S_SRT_LDW;
        end
      end
      S_SRT_LDW: begin
        ctl_o.cap_k = 1'b1;
        state_d     = S_SRT_RD;
      end
      // insertion sort, inner step
      S_SRT_RD: begin
        if (sts_i.j_zero) begin
          ctl_o.place_wr = 1'b1;
          state_d        = S_SRT_LD;
        end else begin
          ctl_o.rd_jm1 = 1'b1;
          state_d      = S_SRT_CMP;
        end
      end
      S_SRT_CMP: begin
        if (sts_i.key_gt) begin
          ctl_o.shift_wr = 1'b1;
          state_d        = S_SRT_RD;
        end else begin
          ctl_o.place_wr = 1'b1;
          state_d        = S_SRT_LD;
        end
      end
      // binary search
      S_PROBE: begin
        if (sts_i.open) begin
          ctl_o.probe = 1'b1;
          state_d     = S_SCMP;
        end else begin
          code_d  = ST_MISS;
          state_d = S_DONE;
        end
      end
      S_SCMP: begin
        if (sts_i.hit) begin
          ctl_o.hit_cap = 1'b1;
          code_d        = ST_OK;
          state_d       = S_DONE;
        end else begin
          ctl_o.srch_upd = 1'b1;
          state_d        = S_PROBE;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          ctl_o.res_wr = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and held command info
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_OK;
      srch_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
      srch_q  <= srch_d;
    end
  end

  // checks
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE) else $error("accepted word left no work");
  a_res_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.res_wr |-> state_q == S_DONE) else $error("result outside done state");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_o.app_wr, ctl_o.shift_wr, ctl_o.place_wr}))
    else $error("two memory writes at once");

endmodule

/* rtl/sorted_table_binary_search.sv */
// Steps, accept through result load: append goes S_APPEND, S_DONE; a sorted table's sort goes
// to S_DONE; sort runs S_SRT_LD, S_SRT_LDW per record after the first, S_SRT_RD, S_SRT_CMP per
// place moved; search runs S_PROBE, S_SCMP per probe (at most floor(log2 n) + 1), after any sort.
// Throughput: one command at a time over the single memory read port; the next word is taken
// the cycle after the result load, and an untaken result holds the next one in its done cycle.
// Reset (async, active low) empties the table; memory contents need no clearing.
module sorted_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [stbs_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,  // key, cost
  input  logic [stbs_pkg::CMD_W-1:0]        s_axis_tuser_i,  // command
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [stbs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,  // found_index, found_cost,
                                                             // entry_count, zero fill
  output logic [stbs_pkg::STAT_W-1:0]       m_axis_tuser_o   // status
);
  import stbs_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // command sequencing
  stbs_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .cmd_i           (s_axis_tuser_i),
    .sts_i           (sts),
    .ctl_o           (ctl)
  );

  // table and result datapath
  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .in_tdata_i      (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule
